/* sv/fsp_pkg.sv */
package fsp_pkg;

  // Packed stream format.
  localparam int SYMBOL_BITS = 5;
  localparam int PEND_BITS   = SYMBOL_BITS - 1;
  localparam int PCNT_W      = $clog2(SYMBOL_BITS);

  // Input field widths.
  localparam int VALUE_W = 48;
  localparam int GAIN_W  = 32;
  localparam int FW_W    = 6;

  // Scaling datapath.
  localparam int SUM_W     = VALUE_W + 1;
  localparam int MUL_SPLIT = 32;
  localparam int MULH_W    = SUM_W - MUL_SPLIT + GAIN_W;
  localparam int MULL_W    = MUL_SPLIT + GAIN_W;
  localparam int PROD_W    = SUM_W + GAIN_W + 1;
  localparam int CAP_EXP   = 33;
  localparam int MAG_W     = CAP_EXP + 1;

  // Entries in the queue between the scaling pipeline and the packer.
  localparam int QUEUE_DEPTH = 4;

  typedef logic [PEND_BITS-1:0] pend_t;
  typedef logic [PCNT_W-1:0]    pcnt_t;
  typedef logic [MAG_W-1:0]     mag_t;

endpackage

/* sv/fsp_front.sv */
module fsp_front #(
  parameter int MAX_FIELD_BITS = 32,
  parameter int FRACTION_BITS  = 16,
  localparam int WW = $clog2(MAX_FIELD_BITS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fsp_pkg::VALUE_W-1:0] raw_value,
  input  logic signed [fsp_pkg::VALUE_W-1:0] offset_value,
  input  logic [fsp_pkg::GAIN_W-1:0]        gain,
  input  logic [fsp_pkg::FW_W-1:0]          field_width,
  input  logic                              is_signed,
  input  logic                              last_field,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [MAX_FIELD_BITS-1:0]         out_code,
  output logic [WW-1:0]                     out_rem,
  output logic                              out_last
);

  localparam int RND_SH = 2 * FRACTION_BITS;
  localparam logic [fsp_pkg::PROD_W-1:0] HALF = fsp_pkg::PROD_W'(1) << (RND_SH - 1);

  logic [7:1] vld;
  logic       adv;

  logic [fsp_pkg::SUM_W-1:0]  sum1;
  logic [fsp_pkg::GAIN_W-1:0] gain1;
  logic [fsp_pkg::SUM_W-1:0]  mag2;
  logic [fsp_pkg::GAIN_W-1:0] gain2;
  logic [fsp_pkg::MULL_W-1:0] p0_3;
  logic [fsp_pkg::MULH_W-1:0] p1_3;
  logic [fsp_pkg::PROD_W-1:0] prod4;
  fsp_pkg::mag_t              q5;
  logic [MAX_FIELD_BITS-1:0]  code6;
  logic [MAX_FIELD_BITS-1:0]  code7;
  logic [WW-1:0]              rem7;

  logic [WW-1:0] w_s    [1:6];
  logic          sgn_s  [1:5];
  logic          neg_s  [2:5];
  logic          last_s [1:7];

  logic [fsp_pkg::PROD_W-1:0] qfull;
  logic                       over;
  fsp_pkg::mag_t              lim_neg;
  fsp_pkg::mag_t              lim_pos;
  fsp_pkg::mag_t              lim;
  fsp_pkg::mag_t              mag_cl;
  fsp_pkg::mag_t              val;

  // The whole pipeline moves together; it holds only when its last stage
  // is full and the queue cannot take the request.
  assign adv      = !vld[7] || out_ready;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:1], in_valid};
    end
  end

  always_comb begin
    qfull = prod4 >> RND_SH;
    over  = (|qfull[fsp_pkg::PROD_W-1:fsp_pkg::MAG_W]) ||
            (qfull[fsp_pkg::CAP_EXP] && (|qfull[fsp_pkg::CAP_EXP-1:0]));
  end

  // Clamp in the magnitude domain: a negative value is limited to 2^(w-1)
  // when signed and to zero when unsigned.
  always_comb begin
    lim_neg = (fsp_pkg::MAG_W'(1) << w_s[5]) >> 1;
    lim_pos = sgn_s[5] ? (lim_neg - fsp_pkg::MAG_W'(1))
                       : ((fsp_pkg::MAG_W'(1) << w_s[5]) - fsp_pkg::MAG_W'(1));
    lim     = neg_s[5] ? lim_neg : lim_pos;
    mag_cl  = (q5 > lim) ? lim : q5;
    if (neg_s[5]) begin
      val = sgn_s[5] ? (fsp_pkg::MAG_W'(0) - mag_cl) : '0;
    end else begin
      val = mag_cl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum1  <= {raw_value[fsp_pkg::VALUE_W-1], raw_value} +
               {offset_value[fsp_pkg::VALUE_W-1], offset_value};
      gain1 <= gain;
      w_s[1] <= (field_width > fsp_pkg::FW_W'(MAX_FIELD_BITS)) ?
                WW'(MAX_FIELD_BITS) : WW'(field_width);
      sgn_s[1]  <= is_signed;
      last_s[1] <= last_field;

      neg_s[2] <= sum1[fsp_pkg::SUM_W-1];
      mag2     <= sum1[fsp_pkg::SUM_W-1] ? (fsp_pkg::SUM_W'(0) - sum1) : sum1;
      gain2    <= gain1;

      p0_3     <= mag2[fsp_pkg::MUL_SPLIT-1:0] * gain2;
      p1_3     <= mag2[fsp_pkg::SUM_W-1:fsp_pkg::MUL_SPLIT] * gain2;
      neg_s[3] <= neg_s[2];

      prod4    <= (fsp_pkg::PROD_W'(p1_3) << fsp_pkg::MUL_SPLIT) +
                  fsp_pkg::PROD_W'(p0_3) + HALF;
      neg_s[4] <= neg_s[3];

      q5       <= over ? (fsp_pkg::MAG_W'(1) << fsp_pkg::CAP_EXP)
                       : qfull[fsp_pkg::MAG_W-1:0];
      neg_s[5] <= neg_s[4];

      code6    <= val[MAX_FIELD_BITS-1:0];

      // Left-align so the packer always takes bits from the top.
      code7 <= code6 << (WW'(MAX_FIELD_BITS) - w_s[6]);
      rem7  <= w_s[6];

      for (int i = 2; i <= 6; i++) begin
        w_s[i] <= w_s[i-1];
      end
      for (int i = 2; i <= 5; i++) begin
        sgn_s[i] <= sgn_s[i-1];
      end
      for (int i = 2; i <= 7; i++) begin
        last_s[i] <= last_s[i-1];
      end
    end
  end

  assign out_valid = vld[7];
  assign out_code  = code7;
  assign out_rem   = rem7;
  assign out_last  = last_s[7];

endmodule

/* sv/fsp_fifo.sv */
module fsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

/* sv/fsp_back.sv */
module fsp_back #(
  parameter int MAX_FIELD_BITS = 32,
  localparam int WW = $clog2(MAX_FIELD_BITS + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [MAX_FIELD_BITS-1:0]           item_code,
  input  logic [WW-1:0]                       item_rem,
  input  logic                                item_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fsp_pkg::SYMBOL_BITS-1:0]     symbol,
  output logic                                last_symbol
);

  localparam int SB = fsp_pkg::SYMBOL_BITS;
  localparam int PB = fsp_pkg::PEND_BITS;
  localparam int CW = fsp_pkg::PCNT_W;

  logic                      busy;
  logic [MAX_FIELD_BITS-1:0] code;
  logic [WW-1:0]             rem;
  logic                      last;
  fsp_pkg::pend_t            pend;
  fsp_pkg::pcnt_t            pcnt;

  logic                      out_free;
  logic                      step;
  logic                      take;
  logic [CW-1:0]             need;
  logic [SB-1:0]             top5;
  logic [PB-1:0]             top4;
  logic [PB-1:0]             top4_sh;
  logic [PB+SB-1:0]          window;
  logic [SB-1:0]             sym_val;
  logic                      full;
  logic [MAX_FIELD_BITS-1:0] code_sh;
  logic [WW-1:0]             r2;
  logic [CW-1:0]             comb_cnt;

  logic                      emit;
  logic                      emit_last;
  logic                      done;
  logic [MAX_FIELD_BITS-1:0] code_next;
  logic [WW-1:0]             rem_next;
  fsp_pkg::pend_t            pend_next;
  fsp_pkg::pcnt_t            pcnt_next;

  assign out_free   = !out_valid || !out_stall;
  assign step       = busy && out_free;
  assign item_ready = !busy || (step && done);
  assign take       = item_valid && item_ready;

  // Pending bits are right-aligned with zeros above them, and the field is
  // left-aligned with zeros below its remaining bits, so one shift of the
  // joined window gives both a full symbol and a zero-padded flush.
  always_comb begin
    need     = CW'(SB) - pcnt;
    top5     = code[MAX_FIELD_BITS-1 -: SB];
    top4     = code[MAX_FIELD_BITS-1 -: PB];
    window   = {pend, top5};
    sym_val  = SB'(window >> pcnt);
    full     = (rem >= WW'(need));
    code_sh  = code << need;
    top4_sh  = code_sh[MAX_FIELD_BITS-1 -: PB];
    r2       = rem - WW'(need);
    comb_cnt = pcnt + CW'(rem);
  end

  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    done      = 1'b0;
    code_next = code;
    rem_next  = rem;
    pend_next = pend;
    pcnt_next = pcnt;
    if (full) begin
      emit      = 1'b1;
      code_next = code_sh;
      rem_next  = r2;
      pend_next = '0;
      pcnt_next = '0;
      if (r2 == '0) begin
        done      = 1'b1;
        emit_last = last;
      end else if ((r2 < WW'(SB)) && !last) begin
        // The tail of the field fits in the pending register right away.
        done      = 1'b1;
        pend_next = PB'(top4_sh >> (CW'(PB) - CW'(r2)));
        pcnt_next = CW'(r2);
      end
    end else begin
      done = 1'b1;
      if (last) begin
        emit      = (comb_cnt != '0);
        emit_last = 1'b1;
        pend_next = '0;
        pcnt_next = '0;
      end else begin
        pend_next = PB'({pend, top4} >> (CW'(PB) - CW'(rem)));
        pcnt_next = comb_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= '0;
      pcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        pend <= pend_next;
        pcnt <= pcnt_next;
      end
      if (take) begin
        busy <= 1'b1;
      end else if (step && done) begin
        busy <= 1'b0;
      end
      if (out_free) begin
        out_valid <= step && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code <= item_code;
      rem  <= item_rem;
      last <= item_last;
    end else if (step) begin
      code <= code_next;
      rem  <= rem_next;
    end
    if (step && emit) begin
      symbol      <= sym_val;
      last_symbol <= emit_last;
    end
  end

endmodule

/* sv/scaled_field_five_bit_packer.sv */
// The first symbol of a field passes through seven stages of scaling and
// clamping, the queue, and the packer. The packer works on one field at a
// time and takes the next once it is done; a 32-bit last field can complete
// or flush up to 8 5-bit symbols.
// Reset (synchronous, active high) empties the pipeline and queue, clears the
// partial symbol and drops any undelivered symbol.
module scaled_field_five_bit_packer #(
  parameter int MAX_FIELD_BITS = 32,
  parameter int FRACTION_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [fsp_pkg::VALUE_W-1:0] raw_value,
  input  logic signed [fsp_pkg::VALUE_W-1:0] offset_value,
  input  logic [fsp_pkg::GAIN_W-1:0]         gain,
  input  logic [fsp_pkg::FW_W-1:0]           field_width,
  input  logic                               is_signed,
  input  logic                               last_field,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fsp_pkg::SYMBOL_BITS-1:0]    symbol,
  output logic                               last_symbol
);

  localparam int WW = $clog2(MAX_FIELD_BITS + 1);
  localparam int QW = MAX_FIELD_BITS + WW + 1;

  logic                      f_valid;
  logic                      f_ready;
  logic [MAX_FIELD_BITS-1:0] f_code;
  logic [WW-1:0]             f_rem;
  logic                      f_last;

  logic                      q_valid;
  logic                      q_ready;
  logic [QW-1:0]             q_data;

  fsp_front #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_value    (raw_value),
    .offset_value (offset_value),
    .gain         (gain),
    .field_width  (field_width),
    .is_signed    (is_signed),
    .last_field   (last_field),
    .out_valid    (f_valid),
    .out_ready    (f_ready),
    .out_code     (f_code),
    .out_rem      (f_rem),
    .out_last     (f_last)
  );

  fsp_fifo #(
    .WIDTH (QW),
    .DEPTH (fsp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_code, f_rem, f_last}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  fsp_back #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (q_valid),
    .item_ready  (q_ready),
    .item_code   (q_data[QW-1 -: MAX_FIELD_BITS]),
    .item_rem    (q_data[WW:1]),
    .item_last   (q_data[0]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .last_symbol (last_symbol)
  );

endmodule

/* sv/fsp_checker.sv */
module fsp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [fsp_pkg::SYMBOL_BITS-1:0] symbol,
  input logic                            last_symbol
);

  // A symbol that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(last_symbol))
    else $error("stalled symbol changed or was dropped");

  // Reset leaves nothing to deliver.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("symbol presented right after reset");

  // Reset empties the scaling pipeline, so requests are taken at once.
  a_reset_ready: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind scaled_field_five_bit_packer fsp_checker u_fsp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .symbol      (symbol),
  .last_symbol (last_symbol)
);

/* dv/scaled_field_five_bit_packer_tb.sv */
module scaled_field_five_bit_packer_tb;

  localparam int     FIELD_BITS_MAX = 32;
  localparam int     FRAC_BITS      = 16;
  localparam longint ONE            = 64'sd65536;
  localparam longint VAL_MAX        = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint VAL_MIN        = -64'sh0000_8000_0000_0000;
  localparam logic [fsp_pkg::GAIN_W-1:0] UNITY = 32'h0001_0000;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     DRAIN_CYCLES   = 24;

  typedef struct {
    logic signed [fsp_pkg::VALUE_W-1:0] raw;
    logic signed [fsp_pkg::VALUE_W-1:0] offset;
    logic [fsp_pkg::GAIN_W-1:0]         gain;
    logic [fsp_pkg::FW_W-1:0]           width;
    logic                               sgn;
    logic                               last;
  } field_req_t;

  typedef struct {
    logic [fsp_pkg::SYMBOL_BITS-1:0] symbol;
    logic                            is_last;
  } sym_rec_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic signed [fsp_pkg::VALUE_W-1:0] raw_value = '0;
  logic signed [fsp_pkg::VALUE_W-1:0] offset_value = '0;
  logic [fsp_pkg::GAIN_W-1:0]         gain = '0;
  logic [fsp_pkg::FW_W-1:0]           field_width = '0;
  logic                               is_signed = 1'b0;
  logic                               last_field = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [fsp_pkg::SYMBOL_BITS-1:0]    symbol;
  logic                               last_symbol;

  // Symbols the packer still owes, oldest first, and the partial symbol it holds.
  sym_rec_t                        symbols_due[$];
  logic [fsp_pkg::SYMBOL_BITS-1:0] acc_bits = '0;
  int                              acc_count = 0;

  int       err_count = 0;
  int       idle_cycles = 0;
  bit       in_idling = 1'b1;
  bit       out_idling = 1'b1;
  int       stall_left = 0;
  int       run_left = 0;
  sym_rec_t due;

  scaled_field_five_bit_packer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_value    (raw_value),
    .offset_value (offset_value),
    .gain         (gain),
    .field_width  (field_width),
    .is_signed    (is_signed),
    .last_field   (last_field),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol       (symbol),
    .last_symbol  (last_symbol)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 50);
  endfunction

  // (value + offset) * gain, rounded half away from zero, magnitude capped at 2^33.
  function automatic longint scaled_integer(field_req_t f);
    logic [fsp_pkg::SUM_W-1:0] sum;
    logic [fsp_pkg::SUM_W-1:0] mag;
    logic [81:0]               prod;
    logic [49:0]               q;
    longint                    v;
    sum  = {f.raw[fsp_pkg::VALUE_W-1], f.raw} + {f.offset[fsp_pkg::VALUE_W-1], f.offset};
    mag  = sum[fsp_pkg::SUM_W-1] ? (~sum + 1'b1) : sum;
    prod = 82'(mag) * 82'(f.gain) + (82'd1 << (2 * FRAC_BITS - 1));
    q    = 50'(prod >> (2 * FRAC_BITS));
    if (q > (50'd1 << fsp_pkg::CAP_EXP)) begin
      q = 50'd1 << fsp_pkg::CAP_EXP;
    end
    v = longint'(q);
    return sum[fsp_pkg::SUM_W-1] ? -v : v;
  endfunction

  // Clamps the field to its width, shifts its bits into the partial symbol and
  // queues every symbol that the field completes or flushes.
  function automatic void pack_field(field_req_t f);
    int                     w;
    longint                 v;
    longint                 lo;
    longint                 hi;
    logic [31:0]            code;
    sym_rec_t               s;
    sym_rec_t               made[$];
    w = (f.width > FIELD_BITS_MAX) ? FIELD_BITS_MAX : int'(f.width);
    if (w > 0) begin
      v = scaled_integer(f);
      if (f.sgn) begin
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
      end else begin
        hi = (longint'(1) <<< w) - 1;
        lo = 0;
      end
      if (v < lo) begin
        v = lo;
      end
      if (v > hi) begin
        v = hi;
      end
      code = 32'(v);
      for (int i = w - 1; i >= 0; i--) begin
        acc_bits = {acc_bits[fsp_pkg::SYMBOL_BITS-2:0], code[i]};
        acc_count++;
        if (acc_count == fsp_pkg::SYMBOL_BITS) begin
          s.symbol  = acc_bits;
          s.is_last = 1'b0;
          made.push_back(s);
          acc_bits  = '0;
          acc_count = 0;
        end
      end
    end
    if (f.last) begin
      if (acc_count > 0) begin
        s.symbol  = acc_bits << (fsp_pkg::SYMBOL_BITS - acc_count);
        s.is_last = 1'b0;
        made.push_back(s);
      end
      // A record that ends with nothing to flush and nothing emitted has no
      // symbol to carry the marker.
      if (made.size() > 0) begin
        made[made.size()-1].is_last = 1'b1;
      end
      acc_bits  = '0;
      acc_count = 0;
    end
    foreach (made[k]) begin
      symbols_due.push_back(made[k]);
    end
  endfunction

  function automatic field_req_t make_field(longint raw, longint offset,
                                            logic [fsp_pkg::GAIN_W-1:0] g, int width,
                                            bit sgn, bit last);
    field_req_t f;
    f.raw    = raw[fsp_pkg::VALUE_W-1:0];
    f.offset = offset[fsp_pkg::VALUE_W-1:0];
    f.gain   = g;
    f.width  = width[fsp_pkg::FW_W-1:0];
    f.sgn    = sgn;
    f.last   = last;
    return f;
  endfunction

  function automatic field_req_t random_field(bit last);
    field_req_t f;
    int         r;
    int         w;
    longint     lo;
    longint     hi;
    longint     t;
    longint     full;
    longint     off;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      w = 0;
    end else if (r < 12) begin
      w = $urandom_range(33, 63);
    end else if (r < 25) begin
      w = ($urandom_range(0, 1) == 1) ? 32 : 1;
    end else begin
      w = $urandom_range(1, 32);
    end
    f.width = w[fsp_pkg::FW_W-1:0];
    f.sgn   = 1'($urandom_range(0, 1));
    f.last  = last;
    if (w > FIELD_BITS_MAX) begin
      w = FIELD_BITS_MAX;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      // Aim at the clamp range of the width, its edges and just past them.
      if (w == 0) begin
        lo = -8;
        hi = 8;
      end else if (f.sgn) begin
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
      end else begin
        hi = (longint'(1) <<< w) - 1;
        lo = 0;
      end
      case ($urandom_range(0, 7))
        0: t = lo;
        1: t = hi;
        2: t = lo - 1;
        3: t = hi + 1;
        default: t = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
      endcase
      if (t > 64'sd4294967295) begin
        t = 64'sd4294967295;
      end
      full = t * ONE + longint'($urandom_range(0, 65535));
      off  = longint'($urandom_range(0, 2097152)) - 64'sd1048576;
      if (full - off > VAL_MAX || full - off < VAL_MIN) begin
        off = full - (full >>> 1);
      end
      f.raw    = 48'(full - off);
      f.offset = 48'(off);
      if ($urandom_range(0, 1) == 1) begin
        f.gain = UNITY;
      end else begin
        f.gain = UNITY + $urandom_range(0, 511) - 256;
      end
    end else if (r < 80) begin
      f.raw    = 48'($signed(24'($urandom)));
      f.offset = 48'($signed(16'($urandom)));
      f.gain   = $urandom;
    end else begin
      // Noise: every bit at random, the record marker too.
      f.raw    = {16'($urandom), $urandom};
      f.offset = {16'($urandom), $urandom};
      f.gain   = $urandom;
      f.last   = 1'($urandom_range(0, 1));
    end
    return f;
  endfunction

  // Presents one request and holds it until the block takes it.
  task automatic send_field(field_req_t f);
    int gap;
    gap = (in_idling && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    raw_value    <= f.raw;
    offset_value <= f.offset;
    gain         <= f.gain;
    field_width  <= f.width;
    is_signed    <= f.sgn;
    last_field   <= f.last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pack_field(f);
  endtask

  task automatic send_records(int count);
    int  sent;
    int  len;
    bit  broken;
    sent = 0;
    while (sent < count) begin
      len    = $urandom_range(1, 8);
      broken = ($urandom_range(0, 11) == 0);
      for (int i = 0; i < len && sent < count; i++) begin
        send_field(random_field((i == len - 1) && !broken));
        sent++;
      end
    end
  endtask

  task automatic test_value_extremes();
    send_field(make_field(VAL_MAX, VAL_MAX, 32'hFFFF_FFFF, 32, 1, 0));
    send_field(make_field(VAL_MIN, VAL_MIN, 32'hFFFF_FFFF, 32, 1, 0));
    send_field(make_field(VAL_MIN, 0, 32'h0000_0000, 32, 0, 0));
    send_field(make_field(VAL_MAX, VAL_MIN, UNITY, 1, 0, 1));
    send_field(make_field(VAL_MAX, 0, 32'h0000_0001, 32, 0, 1));
    send_field(make_field(-ONE, 0, UNITY, 1, 1, 0));
    send_field(make_field(ONE, 0, UNITY, 1, 1, 1));
  endtask

  task automatic test_special_cases();
    // A zero-width field adds nothing; on its own at the end of a record it
    // flushes whatever is pending, or nothing at all.
    send_field(make_field(3 * ONE, 0, UNITY, 0, 0, 0));
    send_field(make_field(5 * ONE, 0, UNITY, 3, 0, 0));
    send_field(make_field(0, 0, UNITY, 0, 0, 1));
    send_field(make_field(0, 0, UNITY, 0, 1, 1));
    // Widths above the maximum behave as the maximum.
    send_field(make_field(-7 * ONE, 0, UNITY, 33, 1, 0));
    send_field(make_field(VAL_MAX, 0, UNITY, 63, 0, 1));
    send_field(make_field(-5 * ONE, 0, UNITY, 8, 0, 0));
    // Halves round away from zero in both directions.
    send_field(make_field(ONE + ONE / 2, 0, UNITY, 4, 1, 0));
    send_field(make_field(-(ONE + ONE / 2), 0, UNITY, 4, 1, 0));
    send_field(make_field(-(ONE / 2), 0, UNITY, 4, 1, 0));
    send_field(make_field(5 * ONE / 2 - 1, 0, UNITY, 4, 0, 0));
    send_field(make_field(ONE, ONE / 2, UNITY, 4, 0, 1));
    send_field(make_field(21 * ONE, 0, UNITY, 5, 0, 1));
    send_field(make_field(3 * ONE, -ONE, 32'h0001_8000, 10, 1, 1));
  endtask

  task automatic test_back_to_back(int count);
    in_idling  = 1'b0;
    out_idling = 1'b0;
    send_records(count);
    in_idling  = 1'b1;
    out_idling = 1'b1;
  endtask

  task automatic test_random_records(int count);
    send_records(count);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_value_extremes();
    test_special_cases();
    test_back_to_back(40);
    test_random_records(400);
    in_valid <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("scaled_field_five_bit_packer regression: pass");
    end else begin
      $display("scaled_field_five_bit_packer regression: fail");
    end
    $finish;
  end

  // Output side: check each delivered symbol, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (symbols_due.size() == 0) begin
        $display("%0t: unexpected symbol: expected none, actual symbol %0d last %0d",
                 $time, symbol, last_symbol);
        err_count++;
      end else begin
        due = symbols_due.pop_front();
        if (symbol !== due.symbol || last_symbol !== due.is_last) begin
          $display("%0t: symbol mismatch: expected symbol %0d last %0d, actual symbol %0d last %0d",
                   $time, due.symbol, due.is_last, symbol, last_symbol);
          err_count++;
        end
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall <= 1'b0;
      run_left--;
    end else begin
      out_stall  <= 1'b0;
      run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
      stall_left = out_idling ? idle_len() : 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
        $display("scaled_field_five_bit_packer regression: fail");
        $finish;
      end
    end
  end

endmodule
